/* design/pif_pkg.sv */
package pif_pkg;

    // Field and register widths.
    localparam int ROW_LEN_W   = 15;
    localparam int ROW_COUNT_W = 14;
    localparam int CFG_DATA_W  = 15;
    localparam int CFG_INDEX_W = 1;
    localparam int RAW_W       = 28;
    localparam int LEN_W       = 16;
    localparam int COL_W       = 15;
    localparam int PROD_W      = ROW_COUNT_W + LEN_W;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_LEN   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT = 1'b1;

    localparam logic [ROW_LEN_W-1:0]   ROW_LEN_RST   = 15'd2400;
    localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST = 14'd800;
    // 800 rows of 2400 data bytes plus one filter byte each.
    localparam logic [RAW_W-1:0]       FRAME_LEN_RST = 28'd1920800;

    localparam int MAX_BLOCK_BYTES_DEF = 65535;

    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [7:0]  ZLIB_CMF  = 8'h78;
    localparam logic [7:0]  ZLIB_FLG  = 8'h01;

    // Queue between the front and the back.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = 2;
    localparam int CMD_CNT_W = 3;

    // Output bytes an item may expand into, in stream order.
    localparam int NUM_STEPS = 18;
    localparam int STEP_W    = 5;
    localparam logic [STEP_W-1:0] STEP_HDR0  = 5'd0;
    localparam logic [STEP_W-1:0] STEP_HDR1  = 5'd1;
    localparam logic [STEP_W-1:0] STEP_A_FIN = 5'd2;
    localparam logic [STEP_W-1:0] STEP_A_L0  = 5'd3;
    localparam logic [STEP_W-1:0] STEP_A_L1  = 5'd4;
    localparam logic [STEP_W-1:0] STEP_A_N0  = 5'd5;
    localparam logic [STEP_W-1:0] STEP_A_N1  = 5'd6;
    localparam logic [STEP_W-1:0] STEP_FILT  = 5'd7;
    localparam logic [STEP_W-1:0] STEP_B_FIN = 5'd8;
    localparam logic [STEP_W-1:0] STEP_B_L0  = 5'd9;
    localparam logic [STEP_W-1:0] STEP_B_L1  = 5'd10;
    localparam logic [STEP_W-1:0] STEP_B_N0  = 5'd11;
    localparam logic [STEP_W-1:0] STEP_B_N1  = 5'd12;
    localparam logic [STEP_W-1:0] STEP_DATA  = 5'd13;
    localparam logic [STEP_W-1:0] STEP_T0    = 5'd14;
    localparam logic [STEP_W-1:0] STEP_T1    = 5'd15;
    localparam logic [STEP_W-1:0] STEP_T2    = 5'd16;
    localparam logic [STEP_W-1:0] STEP_T3    = 5'd17;

    typedef logic [NUM_STEPS-1:0] t_step_mask;

    // One classified input item.
    typedef struct packed {
        logic             hdr;
        logic             a_blk;
        logic             a_final;
        logic [LEN_W-1:0] a_len;
        logic             filt;
        logic             b_blk;
        logic             b_final;
        logic [LEN_W-1:0] b_len;
        logic             data;
        logic [7:0]       px;
        logic             trl;
    } t_cmd;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_end;
    } t_out;

endpackage

/* design/pif_front.sv */
module pif_front #(
    parameter int MAX_BLOCK_BYTES = pif_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pif_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [pif_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_push,
    input  logic [7:0]                          i_pixel_byte,
    input  logic                                i_queue_full,
    output logic                                o_cmd_push,
    output pif_pkg::t_cmd                       o_cmd
);

    localparam logic [pif_pkg::RAW_W-1:0] MaxRaw = pif_pkg::RAW_W'(MAX_BLOCK_BYTES);
    localparam logic [pif_pkg::LEN_W-1:0] MaxLen = pif_pkg::LEN_W'(MAX_BLOCK_BYTES);

    logic [pif_pkg::ROW_LEN_W-1:0]   r_row_len, n_row_len;
    logic [pif_pkg::ROW_COUNT_W-1:0] r_row_count, n_row_count;
    logic [pif_pkg::RAW_W-1:0]       r_frame_len, n_frame_len;
    logic [pif_pkg::RAW_W-1:0]       r_raw, n_raw;
    logic [pif_pkg::LEN_W-1:0]       r_blk, n_blk;
    logic [pif_pkg::COL_W-1:0]       r_col, n_col;
    logic                            r_started, n_started;

    logic [pif_pkg::ROW_LEN_W-1:0]   cfg_rb_eff, rb_eff;
    logic [pif_pkg::ROW_COUNT_W-1:0] cfg_rc_eff;
    logic [pif_pkg::PROD_W-1:0]      prod;
    logic                            accept;

    logic [pif_pkg::RAW_W-1:0] raw0, raw1, raw2;
    logic [pif_pkg::LEN_W-1:0] blk0, blk1, blk2, blk_a, blk_b;
    logic [pif_pkg::COL_W-1:0] col0;
    logic [pif_pkg::COL_W:0]   col_inc;
    logic                      a_end, b_end, frame_end;
    pif_pkg::t_cmd             cmd;

    // The frame length is kept ready from the next register values, so an
    // item right after a write already sees it.
    always_comb begin
        n_row_len   = r_row_len;
        n_row_count = r_row_count;
        if (i_cfg_we && (i_cfg_index == pif_pkg::CFG_ROW_LEN)) begin
            n_row_len = i_cfg_data[pif_pkg::ROW_LEN_W-1:0];
        end
        if (i_cfg_we && (i_cfg_index == pif_pkg::CFG_ROW_COUNT)) begin
            n_row_count = i_cfg_data[pif_pkg::ROW_COUNT_W-1:0];
        end
        cfg_rb_eff = (n_row_len == '0) ? pif_pkg::ROW_LEN_W'(1) : n_row_len;
        cfg_rc_eff = (n_row_count == '0) ? pif_pkg::ROW_COUNT_W'(1) : n_row_count;
        prod = pif_pkg::PROD_W'(cfg_rc_eff)
             * pif_pkg::PROD_W'(pif_pkg::LEN_W'(cfg_rb_eff) + pif_pkg::LEN_W'(1));
        if (prod[pif_pkg::PROD_W-1:pif_pkg::RAW_W] != '0) begin
            n_frame_len = '1;
        end else begin
            n_frame_len = prod[pif_pkg::RAW_W-1:0];
        end
    end

    assign accept     = i_push && !i_queue_full;
    assign o_cmd_push = accept;
    assign o_cmd      = cmd;

    always_comb begin
        rb_eff = (r_row_len == '0) ? pif_pkg::ROW_LEN_W'(1) : r_row_len;

        cmd.hdr = !r_started;
        raw0    = r_started ? r_raw : r_frame_len;
        blk0    = r_started ? r_blk : '0;
        col0    = r_started ? r_col : '0;

        // Filter byte at the start of a row; the frame always has room for it.
        cmd.filt    = (col0 == '0);
        cmd.a_blk   = cmd.filt && (blk0 == '0);
        cmd.a_final = (raw0 <= MaxRaw);
        cmd.a_len   = cmd.a_final ? raw0[pif_pkg::LEN_W-1:0] : MaxLen;
        blk_a       = cmd.a_blk ? cmd.a_len : blk0;
        blk1        = cmd.filt ? (blk_a - pif_pkg::LEN_W'(1)) : blk0;
        raw1        = cmd.filt ? (raw0 - pif_pkg::RAW_W'(1)) : raw0;
        a_end       = cmd.filt && (raw1 == '0);

        // The data byte is dropped when the frame ran out on the filter byte.
        cmd.data    = !a_end;
        cmd.px      = i_pixel_byte;
        cmd.b_blk   = cmd.data && (blk1 == '0);
        cmd.b_final = (raw1 <= MaxRaw);
        cmd.b_len   = cmd.b_final ? raw1[pif_pkg::LEN_W-1:0] : MaxLen;
        blk_b       = cmd.b_blk ? cmd.b_len : blk1;
        blk2        = cmd.data ? (blk_b - pif_pkg::LEN_W'(1)) : blk1;
        raw2        = cmd.data ? (raw1 - pif_pkg::RAW_W'(1)) : raw1;
        b_end       = cmd.data && (raw2 == '0);

        frame_end = a_end || b_end;
        cmd.trl   = frame_end;

        col_inc = {1'b0, col0} + (pif_pkg::COL_W + 1)'(1);
        n_raw     = raw2;
        n_started = !frame_end;
        n_blk     = frame_end ? '0 : blk2;
        if (frame_end) begin
            n_col = '0;
        end else if (col_inc >= (pif_pkg::COL_W + 1)'(rb_eff)) begin
            n_col = '0;
        end else begin
            n_col = col_inc[pif_pkg::COL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_len   <= pif_pkg::ROW_LEN_RST;
            r_row_count <= pif_pkg::ROW_COUNT_RST;
            r_frame_len <= pif_pkg::FRAME_LEN_RST;
            r_raw       <= '0;
            r_blk       <= '0;
            r_col       <= '0;
            r_started   <= 1'b0;
        end else begin
            r_row_len   <= n_row_len;
            r_row_count <= n_row_count;
            r_frame_len <= n_frame_len;
            if (accept) begin
                r_raw     <= n_raw;
                r_blk     <= n_blk;
                r_col     <= n_col;
                r_started <= n_started;
            end
        end
    end

`ifndef ASSERT_OFF
    a_started_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> (r_raw != '0))
        else $error("frame open with no bytes left");
    a_block_within_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> (pif_pkg::RAW_W'(r_blk) <= r_raw))
        else $error("open block longer than the rest of the frame");
    a_end_closes_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd.trl) |=> (!r_started && r_blk == '0 && r_col == '0))
        else $error("frame end did not clear the framing state");
`endif

endmodule

/* design/pif_cmd_fifo.sv */
module pif_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pif_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output pif_pkg::t_cmd o_head
);

    pif_pkg::t_cmd                 r_mem [pif_pkg::CMD_DEPTH];
    logic [pif_pkg::CMD_PTR_W-1:0] r_wr, r_rd;
    logic [pif_pkg::CMD_CNT_W-1:0] r_count;
    logic                          do_push, do_pop;

    assign o_full  = (r_count == pif_pkg::CMD_CNT_W'(pif_pkg::CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + pif_pkg::CMD_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + pif_pkg::CMD_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + pif_pkg::CMD_CNT_W'(1);
                2'b01:   r_count <= r_count - pif_pkg::CMD_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* design/pif_back.sv */
module pif_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  pif_pkg::t_cmd i_head,
    output logic          o_cmd_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_out_byte,
    output logic          o_run_last,
    output logic          o_stream_end
);

    pif_pkg::t_step_mask       r_done, n_done;
    pif_pkg::t_step_mask       head_mask, rem, sel;
    logic [pif_pkg::STEP_W-1:0] idx;
    logic                      emit, last, ofull;
    logic [7:0]                step_byte;

    logic [15:0] r_adl_lo, r_adl_hi;
    logic [16:0] lo_sum, hi_sum;
    logic [15:0] lo_next, hi_next;

    pif_pkg::t_out r_obuf [2];
    logic          r_owr, r_ord;
    logic [1:0]    r_ocnt;
    logic          opush, opop;
    pif_pkg::t_out obyte;

    always_comb begin
        head_mask = '0;
        head_mask[pif_pkg::STEP_HDR0]  = i_head.hdr;
        head_mask[pif_pkg::STEP_HDR1]  = i_head.hdr;
        head_mask[pif_pkg::STEP_A_FIN] = i_head.a_blk;
        head_mask[pif_pkg::STEP_A_L0]  = i_head.a_blk;
        head_mask[pif_pkg::STEP_A_L1]  = i_head.a_blk;
        head_mask[pif_pkg::STEP_A_N0]  = i_head.a_blk;
        head_mask[pif_pkg::STEP_A_N1]  = i_head.a_blk;
        head_mask[pif_pkg::STEP_FILT]  = i_head.filt;
        head_mask[pif_pkg::STEP_B_FIN] = i_head.b_blk;
        head_mask[pif_pkg::STEP_B_L0]  = i_head.b_blk;
        head_mask[pif_pkg::STEP_B_L1]  = i_head.b_blk;
        head_mask[pif_pkg::STEP_B_N0]  = i_head.b_blk;
        head_mask[pif_pkg::STEP_B_N1]  = i_head.b_blk;
        head_mask[pif_pkg::STEP_DATA]  = i_head.data;
        head_mask[pif_pkg::STEP_T0]    = i_head.trl;
        head_mask[pif_pkg::STEP_T1]    = i_head.trl;
        head_mask[pif_pkg::STEP_T2]    = i_head.trl;
        head_mask[pif_pkg::STEP_T3]    = i_head.trl;

        rem = i_head_valid ? (head_mask & ~r_done) : '0;

        // Lowest pending step goes out first.
        idx = '0;
        for (int k = pif_pkg::NUM_STEPS - 1; k >= 0; k--) begin
            if (rem[k]) begin
                idx = pif_pkg::STEP_W'(k);
            end
        end
        sel  = pif_pkg::t_step_mask'(1) << idx;
        last = ((rem & ~sel) == '0);
    end

    always_comb begin
        case (idx)
            pif_pkg::STEP_HDR0:  step_byte = pif_pkg::ZLIB_CMF;
            pif_pkg::STEP_HDR1:  step_byte = pif_pkg::ZLIB_FLG;
            pif_pkg::STEP_A_FIN: step_byte = {7'd0, i_head.a_final};
            pif_pkg::STEP_A_L0:  step_byte = i_head.a_len[7:0];
            pif_pkg::STEP_A_L1:  step_byte = i_head.a_len[15:8];
            pif_pkg::STEP_A_N0:  step_byte = ~i_head.a_len[7:0];
            pif_pkg::STEP_A_N1:  step_byte = ~i_head.a_len[15:8];
            pif_pkg::STEP_FILT:  step_byte = 8'h00;
            pif_pkg::STEP_B_FIN: step_byte = {7'd0, i_head.b_final};
            pif_pkg::STEP_B_L0:  step_byte = i_head.b_len[7:0];
            pif_pkg::STEP_B_L1:  step_byte = i_head.b_len[15:8];
            pif_pkg::STEP_B_N0:  step_byte = ~i_head.b_len[7:0];
            pif_pkg::STEP_B_N1:  step_byte = ~i_head.b_len[15:8];
            pif_pkg::STEP_DATA:  step_byte = i_head.px;
            pif_pkg::STEP_T0:    step_byte = r_adl_hi[15:8];
            pif_pkg::STEP_T1:    step_byte = r_adl_hi[7:0];
            pif_pkg::STEP_T2:    step_byte = r_adl_lo[15:8];
            pif_pkg::STEP_T3:    step_byte = r_adl_lo[7:0];
            default:             step_byte = 8'h00;
        endcase
    end

    assign ofull     = (r_ocnt == 2'd2);
    assign emit      = (rem != '0) && !ofull;
    assign o_cmd_pop = emit && last;

    always_comb begin
        if (emit) begin
            n_done = last ? '0 : (r_done | sel);
        end else begin
            n_done = r_done;
        end
    end

    // Adler-32 over the raw bytes as they leave; the trailer follows the
    // last raw byte, so it reads the sums already updated.
    always_comb begin
        lo_sum  = {1'b0, r_adl_lo} + {9'd0, step_byte};
        lo_next = (lo_sum >= pif_pkg::ADLER_MOD) ? 16'(lo_sum - pif_pkg::ADLER_MOD)
                                                 : lo_sum[15:0];
        hi_sum  = {1'b0, r_adl_hi} + {1'b0, lo_next};
        hi_next = (hi_sum >= pif_pkg::ADLER_MOD) ? 16'(hi_sum - pif_pkg::ADLER_MOD)
                                                 : hi_sum[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done   <= '0;
            r_adl_lo <= 16'd1;
            r_adl_hi <= 16'd0;
        end else begin
            r_done <= n_done;
            if (emit && (idx == pif_pkg::STEP_HDR0)) begin
                r_adl_lo <= 16'd1;
                r_adl_hi <= 16'd0;
            end else if (emit && (idx == pif_pkg::STEP_FILT || idx == pif_pkg::STEP_DATA)) begin
                r_adl_lo <= lo_next;
                r_adl_hi <= hi_next;
            end
        end
    end

    // Two-entry output queue parts the back from the receiver.
    assign obyte.out_byte   = step_byte;
    assign obyte.run_last   = last;
    assign obyte.stream_end = (idx == pif_pkg::STEP_T3);
    assign opush            = emit;
    assign opop             = i_pop && (r_ocnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (opush) begin
            r_obuf[r_owr] <= obyte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= 1'b0;
            r_ord  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (opush) begin
                r_owr <= ~r_owr;
            end
            if (opop) begin
                r_ord <= ~r_ord;
            end
            case ({opush, opop})
                2'b10:   r_ocnt <= r_ocnt + 2'd1;
                2'b01:   r_ocnt <= r_ocnt - 2'd1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    assign o_empty      = (r_ocnt == 2'd0);
    assign o_out_byte   = r_obuf[r_ord].out_byte;
    assign o_run_last   = r_obuf[r_ord].run_last;
    assign o_stream_end = r_obuf[r_ord].stream_end;

`ifndef ASSERT_OFF
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && idx == pif_pkg::STEP_T3) |-> last)
        else $error("stream end byte is not the last byte of its item");
    a_done_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done & ~(i_head_valid ? head_mask : '0)) == '0)
        else $error("sent steps not part of the head item");
    a_adler_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_adl_lo} < pif_pkg::ADLER_MOD) && ({1'b0, r_adl_hi} < pif_pkg::ADLER_MOD))
        else $error("Adler sum out of range");
    a_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ocnt != 2'd3))
        else $error("output queue overfilled");
`endif

endmodule

/* design/png_idat_stored_zlib_framer_unit.sv */
// PNG IDAT framer: wraps raster image bytes into a zlib stream of stored
// deflate blocks with an Adler-32 trailer.
// Input channel: an item is one image byte on i_pixel_byte, taken on a clock
// edge with push high and full low. Output channel: while empty is low the
// oldest stream byte is on o_out_byte, with o_run_last marking the last byte
// produced by one item and o_stream_end marking the final Adler-32 byte;
// pop takes it.
// Configuration: i_cfg_we writes i_cfg_data into the row length in bytes
// (index 0) or row_count (index 1); write only between frames or while no bytes
// are in flight. The frame length is latched when the first byte of a frame arrives.
// The first byte of an item passes through the command queue, then the output queue,
// before it can be popped. Throughput: one output byte per cycle from the expansion
// unit while the output queue has room; an ordinary data byte is one output byte, so
// items flow at one per cycle, while items carrying the zlib header, a filter byte,
// a block header or trailer hold the expander; the four-entry command queue fills.
// Reset clears the framing state and queues, restarts the Adler sums and restores
// rows of 2400 bytes and row_count 800. A stalled receiver fills the two-entry
// output queue, then the command queue, then full rises; nothing is lost.
module png_idat_stored_zlib_framer_unit #(
    parameter int MAX_BLOCK_BYTES = pif_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pif_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [pif_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      i_pixel_byte,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      o_out_byte,
    output logic                            o_run_last,
    output logic                            o_stream_end
);

    logic          cmd_push, cmd_pop, cmd_full, cmd_valid;
    pif_pkg::t_cmd cmd_in, cmd_head;

    assign full = cmd_full;

    pif_front #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .i_pixel_byte (i_pixel_byte),
        .i_queue_full (cmd_full),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in)
    );

    pif_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_full  (cmd_full),
        .o_valid (cmd_valid),
        .o_head  (cmd_head)
    );

    pif_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (cmd_valid),
        .i_head       (cmd_head),
        .o_cmd_pop    (cmd_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_stream_end (o_stream_end)
    );

endmodule
